// ----- design/bctp_pkg.sv -----
// ----------------------------------------------------------------------------
// bctp_pkg: shared types and constants
// Item and result layouts, register indexes, band and pulse constants for the
// boiler thermostat pulse control block.
// ----------------------------------------------------------------------------
package bctp_pkg;

	localparam int unsigned PULSE_PERIOD_MS_DEF = 1000;

	// fixed point temperatures, 1/16 degC
	localparam int BAND_WIDE   = 160;
	localparam int BAND_NARROW = 80;
	localparam int STEAM_BAND  = 160;
	localparam int PCT_NEAR    = 75;
	localparam int PCT_CLOSE   = 50;
	localparam logic [7:0] WATER_PUMP_VALUE = 8'd50;

	// temperature arithmetic width (16 bit signed plus 12 bit signed plus band)
	localparam int TEMP_W = 18;

	localparam logic [1:0] REQ_COFFEE    = 2'd0;
	localparam logic [1:0] REQ_STEAM     = 2'd1;
	localparam logic [1:0] REQ_HOT_WATER = 2'd2;

	typedef enum logic [2:0] {
		REG_BREW_SETPOINT    = 3'd0,
		REG_TEMP_OFFSET      = 3'd1,
		REG_STEAM_SETPOINT   = 3'd2,
		REG_STEAM_PULSE_PCT  = 3'd3,
		REG_STEAM_PUMP_VALUE = 3'd4,
		REG_STEAM_PRESS_LIM  = 3'd5,
		REG_STEAM_TIMEOUT    = 3'd6,
		REG_WATER_CUTOFF     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        brew_setpoint;
		logic signed [11:0] temp_offset;
		logic [11:0]        steam_setpoint;
		logic [6:0]         steam_pulse_percent;
		logic [7:0]         steam_pump_value;
		logic [15:0]        steam_pressure_limit;
		logic [31:0]        steam_timeout_ms;
		logic [11:0]        water_cutoff;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        now_ms;
		logic signed [15:0] temperature;
		logic               brew_active;
		logic               brew_switch;
		logic               steam_switch;
		logic [15:0]        pressure;
	} req_item_t;

	typedef struct packed {
		logic       boiler_on;
		logic       steam_valve_off;
		logic       steam_relay_off;
		logic       pump_write;
		logic [7:0] pump_value;
		logic       display_write;
		logic       display_mode;
		logic       steam_forgotten;
	} rsp_item_t;

endpackage

// ----- design/bctp_req_if.sv -----
// ----------------------------------------------------------------------------
// bctp_req_if: control tick channel
// Valid/ready channel carrying one control tick per beat.
// ----------------------------------------------------------------------------
interface bctp_req_if import bctp_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/bctp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bctp_rsp_if: command result channel
// Valid/ready channel carrying one set of heater and steam commands per beat.
// ----------------------------------------------------------------------------
interface bctp_rsp_if import bctp_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/boiler_thermostat_pulse_control.sv -----
// ----------------------------------------------------------------------------
// boiler_thermostat_pulse_control: boiler heater and steam command controller
// Input register, decision logic and result register lie between a tick and its result.
// Throughput: one tick per cycle while the result channel is not stalled.
// The control state feeds back to the next tick, so ticks retire back to back.
// Reset: arst_n clears heater, pulse phase, steam timer and loads register defaults.
// ----------------------------------------------------------------------------
module boiler_thermostat_pulse_control import bctp_pkg::*; #(
	parameter int unsigned PULSE_PERIOD_MS = PULSE_PERIOD_MS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	bctp_req_if.sink    req,
	bctp_rsp_if.source  rsp
);

	cfg_t      cfg;
	req_item_t item_s1;
	logic      valid_s1;
	rsp_item_t result;
	rsp_item_t rsp_data_q;
	logic      rsp_valid_q;
	logic      advance, fire;

	bctp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.cfg     (cfg)
	);

	assign advance   = ~rsp_valid_q | rsp.ready;
	assign fire      = valid_s1 & advance;
	assign req.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	bctp_core #(
		.PULSE_PERIOD_MS(PULSE_PERIOD_MS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.item  (item_s1),
		.fire  (fire),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ----- design/bctp_cfg.sv -----
// ----------------------------------------------------------------------------
// bctp_cfg: configuration registers
// Write-only register bank for setpoints, offset, pulse and steam settings.
// ----------------------------------------------------------------------------
module bctp_cfg import bctp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brew_setpoint        <= 12'd1488;
			cfg_q.temp_offset          <= 12'sd0;
			cfg_q.steam_setpoint       <= 12'd2480;
			cfg_q.steam_pulse_percent  <= 7'd50;
			cfg_q.steam_pump_value     <= 8'd0;
			cfg_q.steam_pressure_limit <= 16'd384;
			cfg_q.steam_timeout_ms     <= 32'd900000;
			cfg_q.water_cutoff         <= 12'd1360;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_BREW_SETPOINT:    cfg_q.brew_setpoint        <= cfg_data[11:0];
				REG_TEMP_OFFSET:      cfg_q.temp_offset          <= $signed(cfg_data[11:0]);
				REG_STEAM_SETPOINT:   cfg_q.steam_setpoint       <= cfg_data[11:0];
				REG_STEAM_PULSE_PCT:  cfg_q.steam_pulse_percent  <= cfg_data[6:0];
				REG_STEAM_PUMP_VALUE: cfg_q.steam_pump_value     <= cfg_data[7:0];
				REG_STEAM_PRESS_LIM:  cfg_q.steam_pressure_limit <= cfg_data[15:0];
				REG_STEAM_TIMEOUT:    cfg_q.steam_timeout_ms     <= cfg_data;
				REG_WATER_CUTOFF:     cfg_q.water_cutoff         <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/bctp_core.sv -----
// ----------------------------------------------------------------------------
// bctp_core: thermostat decision logic and control state
// Band compares, water cutoff, pulse timing and steam timer for one registered tick; the
// heater, pulse and steam timer state advances when the tick is retired.
// ----------------------------------------------------------------------------
module bctp_core import bctp_pkg::*; #(
	parameter int unsigned PULSE_PERIOD_MS = PULSE_PERIOD_MS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  req_item_t item,
	input  logic      fire,
	output rsp_item_t result
);

	localparam int TW = $clog2(PULSE_PERIOD_MS + 1);
	localparam logic [TW-1:0] PERIOD  = TW'(PULSE_PERIOD_MS);
	localparam logic [TW-1:0] ON_NEAR = TW'(PCT_NEAR * PULSE_PERIOD_MS / 100);
	localparam logic [TW-1:0] ON_CLOSE = TW'(PCT_CLOSE * PULSE_PERIOD_MS / 100);

	// on time per percent; percentages above 100 saturate to the full period
	logic [TW-1:0] on_tab [0:127];
	for (genvar i = 0; i < 128; i++) begin : g_on_tab
		if (i <= 100) begin : g_in
			assign on_tab[i] = TW'(i * PULSE_PERIOD_MS / 100);
		end else begin : g_sat
			assign on_tab[i] = PERIOD;
		end
	end

	logic        relay_q, phase_q, forg_q;
	logic [31:0] start_q, ref_q;
	logic        relay_d, phase_d, forg_d;
	logic [31:0] start_d, ref_d;

	logic signed [TEMP_W-1:0] sensor, off_ext, sp_brew, sp_steam, temp_ext, max_water;

	assign off_ext   = TEMP_W'(cfg.temp_offset);
	assign temp_ext  = TEMP_W'(item.temperature);
	assign sensor    = temp_ext + off_ext;
	assign sp_brew   = $signed({{(TEMP_W-12){1'b0}}, cfg.brew_setpoint}) + off_ext;
	assign sp_steam  = $signed({{(TEMP_W-12){1'b0}}, cfg.steam_setpoint}) + off_ext;
	assign max_water = $signed({{(TEMP_W-12){1'b0}}, cfg.water_cutoff});

	logic          do_pulse;
	logic [TW-1:0] on_sel;
	logic [TW-1:0] off_sel;
	logic [31:0]   phase_end;
	logic          pulse_due;
	rsp_item_t     res;

	always_comb begin
		do_pulse = 1'b0;
		on_sel   = ON_NEAR;
		relay_d  = relay_q;
		ref_d    = ref_q;
		forg_d   = forg_q;
		res      = '0;
		unique case (item.req_type)
			REQ_COFFEE: begin
				res.display_write = 1'b1;
				if (item.brew_active) begin
					if (sensor <= sp_brew - TEMP_W'(BAND_WIDE)) relay_d = 1'b1;
					else if (sensor <= sp_brew) do_pulse = 1'b1;
					else relay_d = 1'b0;
				end else begin
					if (sensor <= sp_brew - TEMP_W'(BAND_WIDE)) relay_d = 1'b1;
					else if (sensor <= sp_brew - TEMP_W'(BAND_NARROW)) do_pulse = 1'b1;
					else if (sensor < sp_brew) begin
						do_pulse = 1'b1;
						on_sel   = ON_CLOSE;
					end else relay_d = 1'b0;
				end
				res.steam_valve_off = item.brew_active | ~item.brew_switch;
				res.steam_relay_off = 1'b1;
			end
			REQ_STEAM: begin
				res.display_write = 1'b1;
				res.display_mode  = item.steam_switch;
				on_sel            = on_tab[cfg.steam_pulse_percent];
				if (sensor > sp_steam + TEMP_W'(STEAM_BAND)) begin
					relay_d        = 1'b0;
					res.pump_write = 1'b1;
					res.pump_value = cfg.steam_pump_value;
				end else if (sensor > sp_steam) begin
					do_pulse = 1'b1;
				end else if (sensor < sp_steam) begin
					relay_d = 1'b1;
				end
				if (item.pressure > cfg.steam_pressure_limit)
					forg_d = (item.now_ms - ref_q) >= cfg.steam_timeout_ms;
				else
					ref_d = item.now_ms;
			end
			REQ_HOT_WATER: begin
				res.pump_write = 1'b1;
				res.pump_value = WATER_PUMP_VALUE;
				relay_d        = temp_ext < max_water;
			end
			default: ;
		endcase
	end

	assign off_sel   = PERIOD - on_sel;
	assign phase_end = start_q + (phase_q ? 32'(on_sel) : 32'(off_sel));
	assign pulse_due = do_pulse && (item.now_ms > phase_end);

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		result  = res;
		if (pulse_due) begin
			phase_d = ~phase_q;
			start_d = item.now_ms;
		end
		result.boiler_on       = pulse_due ? ~phase_q : relay_d;
		result.steam_forgotten = forg_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q <= 1'b0;
			phase_q <= 1'b0;
			start_q <= '0;
			ref_q   <= '0;
			forg_q  <= 1'b0;
		end else if (fire) begin
			relay_q <= result.boiler_on;
			phase_q <= phase_d;
			start_q <= start_d;
			ref_q   <= ref_d;
			forg_q  <= forg_d;
		end
	end

endmodule
